>>> rtl/core/complex_quadratic_form_diagonal_core_macros.svh
// Assertion macros for the complex quadratic form diagonal core.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef COMPLEX_QUADRATIC_FORM_DIAGONAL_CORE_MACROS_SVH
`define COMPLEX_QUADRATIC_FORM_DIAGONAL_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CQFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CQFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/cqfd_pkg.sv
// Package for the complex quadratic form diagonal core: beat types, function
// codes, sequencer states and default sizes. Depends on nothing.
`timescale 1ns / 1ps

package cqfd_pkg;

	localparam int MAX_DIM_DEFAULT   = 64;
	localparam int ELEM_BITS_DEFAULT = 16;

	localparam int DIM_W = 7;
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	localparam logic [1:0] FN_LOAD_OP  = 2'd0;
	localparam logic [1:0] FN_LOAD_VEC = 2'd1;
	localparam logic [1:0] FN_COMPUTE  = 2'd2;

	localparam logic signed [63:0] VALUE_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] VALUE_MIN = 64'shFFFF_FFFF_8000_0000;

	typedef struct packed {
		logic [1:0]         func;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [15:0] re_part;
		logic signed [15:0] im_part;
	} cmd_t;

	typedef struct packed {
		logic [5:0]         column;
		logic signed [31:0] value;
		logic               last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_READ_VK,
		ST_DOT0,
		ST_DOT1,
		ST_FLUSH,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_TR_ADD,
		ACC_TR_SUB,
		ACC_TI_ADD,
		ACC_S_ADD
	} acc_op_t;

endpackage

>>> rtl/core/cqfd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read. Depends on nothing.
`timescale 1ns / 1ps

module cqfd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/complex_quadratic_form_diagonal_core.sv
// Real part of diag(V^H * A * V) for complex fixed-point matrices.
// Load beats give no result. A compute beat walks every column in
// turn; results appear one per column, each registered from the emit
// state that finishes its column. The single shared multiplier does
// four products per operator element.
// Reset clears control and sets dim to 64; the stores are not cleared.
`timescale 1ns / 1ps

module complex_quadratic_form_diagonal_core #(
	parameter int MAX_DIM   = cqfd_pkg::MAX_DIM_DEFAULT,
	parameter int ELEM_BITS = cqfd_pkg::ELEM_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  cqfd_pkg::cmd_t                cmd,
	input  logic                          cfg_we,
	input  logic [cqfd_pkg::DIM_W-1:0]    cfg_data,
	output logic                          strobe,
	output cqfd_pkg::result_t             result
);

	`include "complex_quadratic_form_diagonal_core_macros.svh"

	localparam int EW    = (ELEM_BITS < 16) ? ELEM_BITS : 16;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	// Partial sums over m, and the column sum over k.
	localparam int TW    = 2 * EW + CW + 2;
	localparam int SW    = EW + TW + CW + 2;
	localparam int PW    = EW + TW;
	localparam int SHIFT = 2 * (ELEM_BITS - 2);

	cqfd_pkg::state_t  state_q, state_d;
	cqfd_pkg::acc_op_t acc_op, ctl_s1;

	logic [cqfd_pkg::DIM_W-1:0] dim_q, dim_eff;
	logic [CW-1:0] i_q, k_q, m_q, n_last_q, n_last;
	logic accept, load_in_range;
	logic op_we, vec_we, op_re, vec_re;
	logic [AW-1:0] waddr, op_raddr, vec_raddr;
	logic [2*EW-1:0] wdata, op_rdata, vec_rdata;
	logic signed [EW-1:0] op_ar, op_ai, vec_r, vec_i;
	logic signed [EW-1:0] mul_a;
	logic signed [TW-1:0] mul_b;
	logic signed [PW-1:0] prod_s1;
	logic signed [TW-1:0] tr_q, ti_q;
	logic signed [SW-1:0] s_q, s_shr;
	logic signed [63:0] s_ext;
	logic clr_t;
	logic strobe_q;
	cqfd_pkg::result_t result_q;

	assign accept = start && !busy;
	assign busy   = (state_q != cqfd_pkg::ST_IDLE);

	// Dimension in use: zero acts as one, oversize acts as the maximum.
	always_comb begin
		if (dim_q == '0) begin
			dim_eff = cqfd_pkg::DIM_W'(1);
		end else if (dim_q > cqfd_pkg::DIM_W'(MAX_DIM)) begin
			dim_eff = cqfd_pkg::DIM_W'(MAX_DIM);
		end else begin
			dim_eff = dim_q;
		end
	end
	assign n_last = CW'(dim_eff - cqfd_pkg::DIM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= cqfd_pkg::DIM_RESET;
		end else if (cfg_we) begin
			dim_q <= cfg_data;
		end
	end

	// Load path writes straight into the stores.
	assign load_in_range = (7'(cmd.row) < 7'(MAX_DIM)) && (7'(cmd.col) < 7'(MAX_DIM));
	assign op_we  = accept && (cmd.func == cqfd_pkg::FN_LOAD_OP) && load_in_range;
	assign vec_we = accept && (cmd.func == cqfd_pkg::FN_LOAD_VEC) && load_in_range;
	assign waddr  = AW'(cmd.row) * AW'(MAX_DIM) + AW'(cmd.col);
	assign wdata  = {cmd.re_part[EW-1:0], cmd.im_part[EW-1:0]};

	cqfd_ram #(.WIDTH(2 * EW), .DEPTH(DEPTH)) u_op_store (
		.clk   (clk),
		.we    (op_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (op_re),
		.raddr (op_raddr),
		.rdata (op_rdata)
	);

	cqfd_ram #(.WIDTH(2 * EW), .DEPTH(DEPTH)) u_vec_store (
		.clk   (clk),
		.we    (vec_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (vec_re),
		.raddr (vec_raddr),
		.rdata (vec_rdata)
	);

	assign op_ar = op_rdata[2*EW-1:EW];
	assign op_ai = op_rdata[EW-1:0];
	assign vec_r = vec_rdata[2*EW-1:EW];
	assign vec_i = vec_rdata[EW-1:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cqfd_pkg::ST_IDLE: begin
				if (accept && cmd.func == cqfd_pkg::FN_COMPUTE) begin
					state_d = cqfd_pkg::ST_READ;
				end
			end
			cqfd_pkg::ST_READ:    state_d = cqfd_pkg::ST_MUL0;
			cqfd_pkg::ST_MUL0:    state_d = cqfd_pkg::ST_MUL1;
			cqfd_pkg::ST_MUL1:    state_d = cqfd_pkg::ST_MUL2;
			cqfd_pkg::ST_MUL2:    state_d = cqfd_pkg::ST_MUL3;
			cqfd_pkg::ST_MUL3: begin
				state_d = (m_q == n_last_q) ? cqfd_pkg::ST_READ_VK : cqfd_pkg::ST_READ;
			end
			cqfd_pkg::ST_READ_VK: state_d = cqfd_pkg::ST_DOT0;
			cqfd_pkg::ST_DOT0:    state_d = cqfd_pkg::ST_DOT1;
			cqfd_pkg::ST_DOT1: begin
				state_d = (k_q == n_last_q) ? cqfd_pkg::ST_FLUSH : cqfd_pkg::ST_READ;
			end
			cqfd_pkg::ST_FLUSH:   state_d = cqfd_pkg::ST_EMIT;
			cqfd_pkg::ST_EMIT: begin
				state_d = (i_q == n_last_q) ? cqfd_pkg::ST_IDLE : cqfd_pkg::ST_READ;
			end
			default:              state_d = cqfd_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: store reads and the operands of the shared multiplier.
	// Per (k, m): t += A[k,m] * V[m,i]. Per k: s += Re(conj(V[k,i]) * t).
	always_comb begin
		op_re     = 1'b0;
		vec_re    = 1'b0;
		op_raddr  = AW'(k_q) * AW'(MAX_DIM) + AW'(m_q);
		vec_raddr = AW'(m_q) * AW'(MAX_DIM) + AW'(i_q);
		mul_a     = vec_r;
		mul_b     = TW'(op_ar);
		acc_op    = cqfd_pkg::ACC_NONE;
		clr_t     = 1'b0;
		case (state_q)
			cqfd_pkg::ST_READ: begin
				op_re  = 1'b1;
				vec_re = 1'b1;
			end
			cqfd_pkg::ST_MUL0: begin
				mul_a  = vec_r;
				mul_b  = TW'(op_ar);
				acc_op = cqfd_pkg::ACC_TR_ADD;
			end
			cqfd_pkg::ST_MUL1: begin
				mul_a  = vec_i;
				mul_b  = TW'(op_ai);
				acc_op = cqfd_pkg::ACC_TR_SUB;
			end
			cqfd_pkg::ST_MUL2: begin
				mul_a  = vec_i;
				mul_b  = TW'(op_ar);
				acc_op = cqfd_pkg::ACC_TI_ADD;
			end
			cqfd_pkg::ST_MUL3: begin
				mul_a  = vec_r;
				mul_b  = TW'(op_ai);
				acc_op = cqfd_pkg::ACC_TI_ADD;
			end
			cqfd_pkg::ST_READ_VK: begin
				vec_re    = 1'b1;
				vec_raddr = AW'(k_q) * AW'(MAX_DIM) + AW'(i_q);
			end
			cqfd_pkg::ST_DOT0: begin
				mul_a  = vec_r;
				mul_b  = tr_q;
				acc_op = cqfd_pkg::ACC_S_ADD;
			end
			cqfd_pkg::ST_DOT1: begin
				mul_a  = vec_i;
				mul_b  = ti_q;
				acc_op = cqfd_pkg::ACC_S_ADD;
				clr_t  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cqfd_pkg::ST_IDLE;
			i_q      <= '0;
			k_q      <= '0;
			m_q      <= '0;
			n_last_q <= '0;
			ctl_s1   <= cqfd_pkg::ACC_NONE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ctl_s1   <= acc_op;
			strobe_q <= (state_q == cqfd_pkg::ST_EMIT);
			if (accept && cmd.func == cqfd_pkg::FN_COMPUTE) begin
				i_q      <= '0;
				k_q      <= '0;
				m_q      <= '0;
				n_last_q <= n_last;
			end
			if (state_q == cqfd_pkg::ST_MUL3) begin
				m_q <= (m_q == n_last_q) ? '0 : m_q + CW'(1);
			end
			if (state_q == cqfd_pkg::ST_DOT1) begin
				k_q <= (k_q == n_last_q) ? '0 : k_q + CW'(1);
			end
			if (state_q == cqfd_pkg::ST_EMIT && i_q != n_last_q) begin
				i_q <= i_q + CW'(1);
			end
		end
	end

	// Shared multiplier, registered, then one accumulate in the following cycle.
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.func == cqfd_pkg::FN_COMPUTE) begin
			tr_q <= '0;
			ti_q <= '0;
			s_q  <= '0;
		end else begin
			if (clr_t) begin
				tr_q <= '0;
				ti_q <= '0;
			end else if (ctl_s1 == cqfd_pkg::ACC_TR_ADD) begin
				tr_q <= tr_q + TW'(prod_s1);
			end else if (ctl_s1 == cqfd_pkg::ACC_TR_SUB) begin
				tr_q <= tr_q - TW'(prod_s1);
			end else if (ctl_s1 == cqfd_pkg::ACC_TI_ADD) begin
				ti_q <= ti_q + TW'(prod_s1);
			end
			if (state_q == cqfd_pkg::ST_EMIT) begin
				s_q <= '0;
			end else if (ctl_s1 == cqfd_pkg::ACC_S_ADD) begin
				s_q <= s_q + SW'(prod_s1);
			end
		end
	end

	// Floor shift back to 14 fraction bits, then saturate to 32 bits.
	assign s_shr = s_q >>> SHIFT;
	assign s_ext = 64'(s_shr);

	always_ff @(posedge clk) begin
		if (state_q == cqfd_pkg::ST_EMIT) begin
			result_q.column <= 6'(i_q);
			result_q.last   <= (i_q == n_last_q);
			if (s_ext > cqfd_pkg::VALUE_MAX) begin
				result_q.value <= cqfd_pkg::VALUE_MAX[31:0];
			end else if (s_ext < cqfd_pkg::VALUE_MIN) begin
				result_q.value <= cqfd_pkg::VALUE_MIN[31:0];
			end else begin
				result_q.value <= s_ext[31:0];
			end
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	`CQFD_ASSERT_NEXT(a_emit_gives_beat, state_q == cqfd_pkg::ST_EMIT, strobe_q, "column finished without a result beat")
	`CQFD_ASSERT_NOW(a_last_then_idle, strobe_q && result_q.last, state_q == cqfd_pkg::ST_IDLE, "last beat while the sequencer still runs")
	`CQFD_ASSERT_NEXT(a_partial_cleared, state_q == cqfd_pkg::ST_DOT1, tr_q == '0 && ti_q == '0, "partial sum not cleared between rows")
	`CQFD_ASSERT_NOW(a_counters_in_range, busy, m_q <= n_last_q && k_q <= n_last_q && i_q <= n_last_q, "loop counter beyond the dimension in use")

endmodule
